[hw/rtl/bmhq_pkg.sv]
// Shared types and codes for the binary max-heap priority queue.
// No dependencies; used by the queue top level.

package bmhq_pkg;

    // Key width of every heap entry
    localparam int unsigned KEY_W = 32;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;
    typedef logic signed [KEY_W-1:0] t_key;

    // Operation codes
    localparam t_op OP_INSERT   = 2'd0;
    localparam t_op OP_REMOVE   = 2'd1;
    localparam t_op OP_INCREASE = 2'd2;
    localparam t_op OP_DECREASE = 2'd3;

    // Result status codes
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_BAD_SLOT  = 3'd3;
    localparam t_status ST_WRONG_DIR = 3'd4;

endpackage

[hw/rtl/bmhq_mem.sv]
// Heap key store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No package dependency.

module bmhq_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/binary_max_heap_queue.sv]
// Binary max-heap priority queue of signed 32-bit keys, top level.
// Uses bmhq_pkg (codes, types) and bmhq_mem (heap key store).
//
// Usage:
//   Command channel: drive i_op, i_new_key, i_slot and raise start; the
//   command transfers at a clock edge where start is high and busy is low.
//   Ops: insert, remove maximum, increase key at slot, decrease key at slot.
//   Result channel: o_done pulses for one cycle with o_status,
//   o_removed_key, o_top_key and o_count; the receiver cannot stall, so the
//   result must be taken in that cycle.
//   Sifting: keys live in one RAM with a registered read port, so the sift
//   walks the tree one level at a time. Each sift-up level (insert, increase
//   key) passes S_UP and S_UPW (parent read, compare/write); each sift-down
//   level (remove, decrease key) passes S_DN, S_DNL and S_DNC (left read,
//   right read, compare/write). o_done rises in the same cycle that busy
//   drops, and the next command may transfer in that same cycle.
//   Reset: synchronous, active low; the heap empties at once (count to 0),
//   no clearing pass over the RAM is needed.

module binary_max_heap_queue #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_new_key,
    input  logic [9:0]  i_slot,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_removed_key,
    output logic [31:0] o_top_key,
    output logic [10:0] o_count
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = CW + 1;
    localparam int unsigned XW = (CW > 10) ? CW : 10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_CHK,
        S_UP,
        S_UPW,
        S_DN,
        S_DNL,
        S_DNC,
        S_FIN
    } t_state;

    t_state            r_state;
    bmhq_pkg::t_op     r_op;
    bmhq_pkg::t_status r_status;
    bmhq_pkg::t_key    r_key;
    bmhq_pkg::t_key    r_lval;
    bmhq_pkg::t_key    r_root;
    bmhq_pkg::t_key    r_removed;
    logic [AW-1:0]     r_pos;
    logic [CW-1:0]     r_cnt;

    logic              r_done;
    logic [2:0]        r_o_status;
    logic [31:0]       r_o_removed;
    logic [31:0]       r_o_top;
    logic [10:0]       r_o_count;

    // RAM port wiring
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [bmhq_pkg::KEY_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [bmhq_pkg::KEY_W-1:0] mem_rdata;
    bmhq_pkg::t_key             rd_key;

    // Tree navigation
    logic [PW-1:0]     n_lc;
    logic [PW-1:0]     n_rc;
    logic [AW-1:0]     n_parent;
    logic              n_lc_in;
    logic              n_rc_in;
    logic              n_left_wins;
    logic              n_right_wins;
    bmhq_pkg::t_key    n_best_val;
    logic              n_slot_bad;
    logic              n_full;

    assign rd_key   = $signed(mem_rdata);
    assign n_lc     = PW'({r_pos, 1'b1});
    assign n_rc     = n_lc + PW'(1);
    assign n_parent = AW'((r_pos - AW'(1)) >> 1);
    assign n_lc_in  = n_lc < PW'(r_cnt);
    assign n_rc_in  = n_rc < PW'(r_cnt);

    // Sift-down compare: left beats parent only if strictly greater,
    // right beats the current winner only if strictly greater
    assign n_left_wins  = r_lval > r_key;
    assign n_best_val   = n_left_wins ? r_lval : r_key;
    assign n_right_wins = n_rc_in && (rd_key > n_best_val);

    assign n_slot_bad = XW'(i_slot) >= XW'(r_cnt);
    assign n_full     = r_cnt == CW'(CAPACITY);

    // RAM read address and write port per state
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_key;
        mem_raddr = r_pos;
        case (r_state)
            S_IDLE: begin
                if (i_op == bmhq_pkg::OP_REMOVE) begin
                    mem_raddr = AW'(r_cnt - CW'(1));
                end else begin
                    mem_raddr = AW'(i_slot);
                end
            end
            S_UP: begin
                mem_raddr = n_parent;
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end
            end
            S_UPW: begin
                mem_we = 1'b1;
                if (rd_key < r_key) begin
                    mem_wdata = rd_key;
                end
            end
            S_DN: begin
                mem_raddr = AW'(n_lc);
                if (!n_lc_in) begin
                    mem_we = 1'b1;
                end
            end
            S_DNL: begin
                mem_raddr = AW'(n_rc);
            end
            S_DNC: begin
                mem_we = 1'b1;
                if (n_right_wins) begin
                    mem_wdata = rd_key;
                end else if (n_left_wins) begin
                    mem_wdata = r_lval;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Command sequencer, result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op      <= i_op;
                        r_key     <= $signed(i_new_key);
                        r_status  <= bmhq_pkg::ST_OK;
                        r_removed <= '0;
                        r_pos     <= AW'(i_slot);
                        case (i_op)
                            bmhq_pkg::OP_INSERT: begin
                                if (n_full) begin
                                    r_status <= bmhq_pkg::ST_FULL;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_pos   <= AW'(r_cnt);
                                    r_cnt   <= r_cnt + CW'(1);
                                    r_state <= S_UP;
                                end
                            end
                            bmhq_pkg::OP_REMOVE: begin
                                if (r_cnt == '0) begin
                                    r_status <= bmhq_pkg::ST_EMPTY;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_removed <= r_root;
                                    r_cnt     <= r_cnt - CW'(1);
                                    r_state   <= S_LAST;
                                end
                            end
                            default: begin
                                if (n_slot_bad) begin
                                    r_status <= bmhq_pkg::ST_BAD_SLOT;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_state <= S_CHK;
                                end
                            end
                        endcase
                    end
                end
                // Last entry arrives; it restarts from the root
                S_LAST: begin
                    r_key <= rd_key;
                    r_pos <= '0;
                    r_state <= (r_cnt == '0) ? S_FIN : S_DN;
                end
                // Old key at slot arrives; check direction
                S_CHK: begin
                    if (r_op == bmhq_pkg::OP_INCREASE) begin
                        if (rd_key > r_key) begin
                            r_status <= bmhq_pkg::ST_WRONG_DIR;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_UP;
                        end
                    end else begin
                        if (rd_key < r_key) begin
                            r_status <= bmhq_pkg::ST_WRONG_DIR;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_DN;
                        end
                    end
                end
                S_UP: begin
                    r_state <= (r_pos == '0) ? S_FIN : S_UPW;
                end
                // Parent arrives: move it down into the hole or settle
                S_UPW: begin
                    if (rd_key < r_key) begin
                        r_pos   <= n_parent;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DN: begin
                    r_state <= n_lc_in ? S_DNL : S_FIN;
                end
                S_DNL: begin
                    r_lval  <= rd_key;
                    r_state <= S_DNC;
                end
                // Right child arrives: pull the winner up or settle
                S_DNC: begin
                    if (n_right_wins) begin
                        r_pos   <= AW'(n_rc);
                        r_state <= S_DN;
                    end else if (n_left_wins) begin
                        r_pos   <= AW'(n_lc);
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_done      <= 1'b1;
                    r_o_status  <= r_status;
                    r_o_removed <= r_removed;
                    r_o_top     <= (r_cnt == '0) ? '0 : r_root;
                    r_o_count   <= 11'(r_cnt);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Root key shadow, follows every write to position zero
    always_ff @(posedge i_clk) begin
        if (mem_we && mem_waddr == '0) begin
            r_root <= $signed(mem_wdata);
        end
    end

    bmhq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (bmhq_pkg::KEY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy          = r_state != S_IDLE;
    assign o_done        = r_done;
    assign o_status      = r_o_status;
    assign o_removed_key = r_o_removed;
    assign o_top_key     = r_o_top;
    assign o_count       = r_o_count;

endmodule
